FILE: rtl/rc4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared constants, controller states and the command and status groups
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package rc4_pkg;

	localparam int TABLE_SIZE = 256;
	localparam int KEY_MAX    = 256;
	localparam int BYTE_W     = 8;
	localparam int ADDR_W     = $clog2(TABLE_SIZE);
	localparam int KCNT_W     = $clog2(TABLE_SIZE) + 1;
	localparam int S_DATA_W   = 2 * BYTE_W;
	localparam int M_DATA_W   = 2 * BYTE_W;

	localparam logic CMD_KEY  = 1'b0;
	localparam logic CMD_DATA = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_KS_RD_I,
		ST_KS_RD_J,
		ST_KS_WR_I,
		ST_KS_WR_J,
		ST_GEN_RD_I,
		ST_GEN_RD_J,
		ST_GEN_WR_I,
		ST_GEN_WR_J,
		ST_GEN_RD_K,
		ST_GEN_OUT,
		ST_BYPASS
	} rc4_state_t;

	typedef struct packed {
		logic key_wr;
		logic data_ld;
		logic init_wr;
		logic ks_rd_i;
		logic ks_rd_j;
		logic ks_wr_i;
		logic ks_wr_j;
		logic gen_rd_i;
		logic gen_rd_j;
		logic gen_wr_i;
		logic gen_wr_j;
		logic gen_rd_k;
		logic out_ks;
		logic out_pass;
	} rc4_cmd_t;

	typedef struct packed {
		logic cnt_last;
		logic keyed;
		logic out_free;
	} rc4_stat_t;

endpackage

FILE: rtl/rc4_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_ctrl
// Sequencer for key loading, the key schedule and keystream generation.
// ----------------------------------------------------------------------------
module rc4_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_command,
	input  logic              in_last,
	output logic              in_ready,
	input  rc4_pkg::rc4_stat_t stat,
	output rc4_pkg::rc4_cmd_t  cmd
);
	import rc4_pkg::*;

	rc4_state_t state_q;
	rc4_state_t state_d;
	logic       accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		accept   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				accept   = in_valid;
				if (accept) begin
					if (in_command == CMD_KEY) begin
						cmd.key_wr = 1'b1;
						if (in_last) begin
							state_d = ST_INIT;
						end
					end else begin
						cmd.data_ld = 1'b1;
						state_d     = stat.keyed ? ST_GEN_RD_I : ST_BYPASS;
					end
				end
			end
			ST_INIT: begin
				cmd.init_wr = 1'b1;
				if (stat.cnt_last) begin
					state_d = ST_KS_RD_I;
				end
			end
			ST_KS_RD_I: begin
				cmd.ks_rd_i = 1'b1;
				state_d     = ST_KS_RD_J;
			end
			ST_KS_RD_J: begin
				cmd.ks_rd_j = 1'b1;
				state_d     = ST_KS_WR_I;
			end
			ST_KS_WR_I: begin
				cmd.ks_wr_i = 1'b1;
				state_d     = ST_KS_WR_J;
			end
			ST_KS_WR_J: begin
				cmd.ks_wr_j = 1'b1;
				state_d     = stat.cnt_last ? ST_IDLE : ST_KS_RD_I;
			end
			ST_GEN_RD_I: begin
				cmd.gen_rd_i = 1'b1;
				state_d      = ST_GEN_RD_J;
			end
			ST_GEN_RD_J: begin
				cmd.gen_rd_j = 1'b1;
				state_d      = ST_GEN_WR_I;
			end
			ST_GEN_WR_I: begin
				cmd.gen_wr_i = 1'b1;
				state_d      = ST_GEN_WR_J;
			end
			ST_GEN_WR_J: begin
				cmd.gen_wr_j = 1'b1;
				state_d      = ST_GEN_RD_K;
			end
			ST_GEN_RD_K: begin
				cmd.gen_rd_k = 1'b1;
				state_d      = ST_GEN_OUT;
			end
			ST_GEN_OUT: begin
				if (stat.out_free) begin
					cmd.out_ks = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_BYPASS: begin
				if (stat.out_free) begin
					cmd.out_pass = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/rc4_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_dp
// State permutation and key memories, stream indices and output register.
// ----------------------------------------------------------------------------
module rc4_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rc4_pkg::rc4_cmd_t                  cmd,
	output rc4_pkg::rc4_stat_t                 stat,
	input  logic [rc4_pkg::S_DATA_W-1:0]       in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [rc4_pkg::M_DATA_W-1:0]       out_data,
	output logic                               out_not_keyed
);
	import rc4_pkg::*;

	logic [BYTE_W-1:0] perm_mem [TABLE_SIZE];
	logic [BYTE_W-1:0] key_mem  [TABLE_SIZE];

	logic [BYTE_W-1:0] perm_rd_q;
	logic [BYTE_W-1:0] key_rd_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [KCNT_W-1:0] pos_q;
	logic [KCNT_W-1:0] key_count_q;
	logic [BYTE_W-1:0] acc_q;
	logic [BYTE_W-1:0] si_q;
	logic [BYTE_W-1:0] sj_q;
	logic [ADDR_W-1:0] i_q;
	logic [ADDR_W-1:0] j_q;
	logic              keyed_q;
	logic [BYTE_W-1:0] data_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] cipher_q;
	logic [BYTE_W-1:0] ks_q;
	logic              not_keyed_q;

	logic [BYTE_W-1:0] key_in;
	logic [BYTE_W-1:0] data_in;
	logic              perm_we;
	logic [ADDR_W-1:0] perm_waddr;
	logic [BYTE_W-1:0] perm_wdata;
	logic              perm_re;
	logic [ADDR_W-1:0] perm_raddr;
	logic              key_we;
	logic [BYTE_W-1:0] acc_n;
	logic [ADDR_W-1:0] i_n;
	logic [ADDR_W-1:0] j_n;
	logic [KCNT_W-1:0] pos_n;
	logic              out_free;

	assign key_in  = in_data[BYTE_W-1:0];
	assign data_in = in_data[2*BYTE_W-1:BYTE_W];
	assign acc_n   = acc_q + perm_rd_q + key_rd_q;
	assign i_n     = i_q + ADDR_W'(1);
	assign j_n     = j_q + perm_rd_q;
	assign pos_n   = pos_q + KCNT_W'(1);
	assign key_we  = cmd.key_wr && (key_count_q < KCNT_W'(KEY_MAX));
	assign out_free = !out_valid_q || out_ready;

	assign stat.cnt_last = (cnt_q == ADDR_W'(TABLE_SIZE - 1));
	assign stat.keyed    = keyed_q;
	assign stat.out_free = out_free;

	always_comb begin
		perm_we    = 1'b0;
		perm_waddr = cnt_q;
		perm_wdata = perm_rd_q;
		perm_re    = 1'b0;
		perm_raddr = cnt_q;
		if (cmd.init_wr) begin
			perm_we    = 1'b1;
			perm_wdata = cnt_q;
		end
		if (cmd.ks_wr_i) begin
			perm_we = 1'b1;
		end
		if (cmd.ks_wr_j) begin
			perm_we    = 1'b1;
			perm_waddr = acc_q;
			perm_wdata = si_q;
		end
		if (cmd.gen_wr_i) begin
			perm_we    = 1'b1;
			perm_waddr = i_q;
		end
		if (cmd.gen_wr_j) begin
			perm_we    = 1'b1;
			perm_waddr = j_q;
			perm_wdata = si_q;
		end
		if (cmd.ks_rd_i) begin
			perm_re = 1'b1;
		end
		if (cmd.ks_rd_j) begin
			perm_re    = 1'b1;
			perm_raddr = acc_n;
		end
		if (cmd.gen_rd_i) begin
			perm_re    = 1'b1;
			perm_raddr = i_n;
		end
		if (cmd.gen_rd_j) begin
			perm_re    = 1'b1;
			perm_raddr = j_n;
		end
		if (cmd.gen_rd_k) begin
			perm_re    = 1'b1;
			perm_raddr = si_q + sj_q;
		end
	end

	always_ff @(posedge clk) begin
		if (perm_we) begin
			perm_mem[perm_waddr] <= perm_wdata;
		end
		if (perm_re) begin
			perm_rd_q <= perm_mem[perm_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_count_q[ADDR_W-1:0]] <= key_in;
		end
		if (cmd.ks_rd_i) begin
			key_rd_q <= key_mem[pos_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.data_ld) begin
			data_q <= data_in;
		end
		if (cmd.ks_rd_j) begin
			si_q <= perm_rd_q;
		end
		if (cmd.gen_rd_j) begin
			si_q <= perm_rd_q;
		end
		if (cmd.gen_wr_i) begin
			sj_q <= perm_rd_q;
		end
		if (cmd.out_ks) begin
			cipher_q    <= data_q ^ perm_rd_q;
			ks_q        <= perm_rd_q;
			not_keyed_q <= 1'b0;
		end
		if (cmd.out_pass) begin
			cipher_q    <= data_q;
			ks_q        <= '0;
			not_keyed_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			pos_q       <= '0;
			key_count_q <= '0;
			acc_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			keyed_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (key_we) begin
				key_count_q <= key_count_q + KCNT_W'(1);
			end
			if (cmd.init_wr) begin
				cnt_q <= cnt_q + ADDR_W'(1);
				pos_q <= '0;
				acc_q <= '0;
			end
			if (cmd.ks_rd_j) begin
				acc_q <= acc_n;
			end
			if (cmd.ks_wr_j) begin
				cnt_q <= cnt_q + ADDR_W'(1);
				pos_q <= (pos_n >= key_count_q) ? '0 : pos_n;
				if (stat.cnt_last) begin
					i_q         <= '0;
					j_q         <= '0;
					key_count_q <= '0;
					keyed_q     <= 1'b1;
				end
			end
			if (cmd.gen_rd_i) begin
				i_q <= i_n;
			end
			if (cmd.gen_rd_j) begin
				j_q <= j_n;
			end
			if (cmd.out_ks || cmd.out_pass) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_data      = {ks_q, cipher_q};
	assign out_not_keyed = not_keyed_q;

endmodule

FILE: rtl/rc4_stream_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 keystream generator and byte cipher with an in-block key schedule.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel. s_axis_tuser selects the kind:
// a key byte or a data byte. Key bytes are stored in order, and the one
// with s_axis_tlast high starts the key schedule, which keeps the block
// busy through an identity fill of the state memory, then 256 swap steps,
// each a read, a read, a write and a write. Key requests give no result.
// Each data request gives one result on the m_axis channel: the cipher
// byte and the keystream byte. A keyed data request passes through the
// dependent reads and writes of the state memory and then waits for the
// output register to free up; the block takes no new request until its
// result is registered. Before any key has been scheduled, data passes
// through unchanged with m_axis_tuser high.
// Reset clears the indices, the key count and the keyed flag; the state
// memory is rebuilt by the next schedule. A result waits in the output
// register while the receiver stalls, and the next request is still taken;
// that request then waits until the register frees up.
// ----------------------------------------------------------------------------
module rc4_stream_cipher (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [rc4_pkg::S_DATA_W-1:0] s_axis_tdata,  // key_byte, data_byte
	input  logic                         s_axis_tlast,  // key_last
	input  logic                         s_axis_tuser,  // command
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [rc4_pkg::M_DATA_W-1:0] m_axis_tdata,  // cipher_byte, keystream_byte
	output logic                         m_axis_tuser   // not_keyed
);
	import rc4_pkg::*;

	rc4_cmd_t  cmd;
	rc4_stat_t stat;

	rc4_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_command (s_axis_tuser),
		.in_last    (s_axis_tlast),
		.in_ready   (s_axis_tready),
		.stat       (stat),
		.cmd        (cmd)
	);

	rc4_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_data       (s_axis_tdata),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_data      (m_axis_tdata),
		.out_not_keyed (m_axis_tuser)
	);

endmodule
